FILE: src/kpl_pkg.sv
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared types and constants for the key to port lookup block.
// ----------------------------------------------------------------------------
package kpl_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BYTES   = 6;
  localparam int KEY_W       = 48;
  localparam int PORT_W      = 16;
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  // Only the low KEY_BYTES bytes of a key take part in a compare.
  localparam int KEY_BITS = (KEY_BYTES * 8 < KEY_W) ? KEY_BYTES * 8 : KEY_W;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

  // Operation codes.
  localparam logic OP_PRELOAD = 1'b0;
  localparam logic OP_LOOKUP  = 1'b1;

  // Result status codes.
  localparam logic [2:0] STAT_FOUND     = 3'd0;
  localparam logic [2:0] STAT_ASSIGNED  = 3'd1;
  localparam logic [2:0] STAT_PRELOADED = 3'd2;
  localparam logic [2:0] STAT_DUPLICATE = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;

  localparam logic [PORT_W-1:0] PORT_MAX = {PORT_W{1'b1}};

  // Input transaction.
  typedef struct packed {
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [PORT_W-1:0] port_in;
  } kpl_in_t;

  // Output transaction.
  typedef struct packed {
    logic [PORT_W-1:0] port_out;
    logic [2:0]        status;
  } kpl_out_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              active;
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [PORT_W-1:0] port;
    logic [FILL_W-1:0] left;
    logic              hit;
    logic              dup;
    logic [PORT_W-1:0] hit_port;
  } kpl_tok_t;

endpackage

FILE: src/kpl_cell.sv
// ----------------------------------------------------------------------------
// kpl_cell
// One table entry. Compares the passing search token against its stored
// pair and hands the updated token to the next cell through its token register.
// ----------------------------------------------------------------------------
module kpl_cell import kpl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kpl_tok_t          tok_i,
  input  logic              wr_en_i,
  input  logic [KEY_W-1:0]  wr_key_i,
  input  logic [PORT_W-1:0] wr_port_i,
  output kpl_tok_t          tok_o
);

  logic [KEY_W-1:0]  key_q;
  logic [PORT_W-1:0] port_q;
  kpl_tok_t          tok_d;
  kpl_tok_t          tok_q;
  logic              live;
  logic              key_eq;
  logic              port_eq;

  // Entry storage, written once when the entry is allocated.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_q  <= wr_key_i;
      port_q <= wr_port_i;
    end
  end

  // The entry takes part only while filled entries remain ahead of the
  // token and no earlier entry has settled the search.
  always_comb begin
    live    = tok_i.active && (tok_i.left != '0) && !tok_i.hit && !tok_i.dup;
    key_eq  = (key_q == tok_i.key);
    port_eq = (port_q == tok_i.port);
    tok_d   = tok_i;
    if (tok_i.left != '0) begin
      tok_d.left = tok_i.left - FILL_W'(1);
    end
    if (live) begin
      if (tok_i.opcode == OP_LOOKUP) begin
        if (key_eq) begin
          tok_d.hit      = 1'b1;
          tok_d.hit_port = port_q;
        end
      end else if (key_eq || port_eq) begin
        tok_d.dup = 1'b1;
      end
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: src/key_to_port_lookup_or_assign.sv
// ----------------------------------------------------------------------------
// key_to_port_lookup_or_assign
// Associative key to port table with automatic port allocation on a miss.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i, in_stall_o, in_data_i) carries one transaction
//   per request: a preload of a key and port pair, or a lookup of a key.
//   Output channel (out_valid_o, out_stall_i, out_data_o) returns exactly one
//   transaction per request with the port and a status code.
//   Each request enters a chain of TABLE_DEPTH cells, one entry per cell, and
//   moves one cell per cycle. The search result register and then the output
//   register follow the last cell. One request is in flight at a time: a new
//   request is taken only after the result of the last one has been committed.
//   The output register frees the input side: the next request is accepted
//   while an earlier result still waits. A held result blocks the commit of
//   the following request until the receiver takes it.
//   Reset empties the table (fill count and highest port go to zero) at once;
//   no clearing pass is needed, as entries are read only below the fill count.
//   While out_valid_o and out_stall_i are both high, out_data_o holds steady.
// ----------------------------------------------------------------------------
module key_to_port_lookup_or_assign import kpl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  kpl_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output kpl_out_t out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [FILL_W-1:0] fill_q;
  logic [PORT_W-1:0] high_q;
  kpl_tok_t          res_q;
  logic              out_valid_q;
  kpl_out_t          out_q;

  kpl_tok_t          tok [TABLE_DEPTH+1];
  kpl_tok_t          tok_head;
  logic              in_accept;
  logic              slot_free;
  logic              commit;
  logic              store;
  logic [PORT_W-1:0] store_port;
  kpl_out_t          result;
  logic              full;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_DONE) && slot_free;
  assign full       = (fill_q == FILL_W'(TABLE_DEPTH));

  // Token entering the first cell.
  always_comb begin
    tok_head          = '0;
    tok_head.active   = in_accept;
    tok_head.opcode   = in_data_i.opcode;
    tok_head.key      = in_data_i.key & KEY_MASK;
    tok_head.port     = in_data_i.port_in;
    tok_head.left     = fill_q;
  end

  assign tok[0] = tok_head;

  // Chain of table cells; the write goes to the cell at the fill count.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic wr_en;
    assign wr_en = store && (fill_q == FILL_W'(i));
    kpl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[i]),
      .wr_en_i   (wr_en),
      .wr_key_i  (res_q.key),
      .wr_port_i (store_port),
      .tok_o     (tok[i+1])
    );
  end

  // Decision on the finished search.
  always_comb begin
    store           = 1'b0;
    store_port      = res_q.port;
    result.port_out = '0;
    result.status   = STAT_FULL;
    if (res_q.opcode == OP_PRELOAD) begin
      if (res_q.dup) begin
        result.status = STAT_DUPLICATE;
      end else if (!full) begin
        store           = commit;
        result.port_out = res_q.port;
        result.status   = STAT_PRELOADED;
      end
    end else begin
      store_port = high_q + PORT_W'(1);
      if (res_q.hit) begin
        result.port_out = res_q.hit_port;
        result.status   = STAT_FOUND;
      end else if (high_q != PORT_MAX && !full) begin
        store           = commit;
        result.port_out = store_port;
        result.status   = STAT_ASSIGNED;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (tok[TABLE_DEPTH].active) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (store) begin
        fill_q <= fill_q + FILL_W'(1);
        if (store_port > high_q) high_q <= store_port;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search result and output payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && tok[TABLE_DEPTH].active) begin
      res_q <= tok[TABLE_DEPTH];
    end
    if (commit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + FILL_W'(1)))
    else $error("fill count moved by more than one");

  a_tok_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[TABLE_DEPTH].active |-> (state_q == ST_SCAN))
    else $error("search token left the chain outside a scan");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed result not presented");

  a_assigned_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STAT_ASSIGNED) |-> (out_q.port_out != '0))
    else $error("assigned port is zero");

endmodule
